>>> rtl/core/bev_pkg.sv
// Shared types, widths and codes of the base extension vote unit.
package bev_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NUM_BASES       = 4;
    localparam int BASE_W          = 2;
    localparam int AMOUNT_W        = 16;
    localparam int KEEP_W          = 17;
    localparam int MIN_DEPTH_W     = 16;
    localparam int FRAC_BITS       = 16;
    localparam int THR_W           = KEEP_W + AMOUNT_W - FRAC_BITS;
    localparam int CODE_W          = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 17;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 8;

    typedef enum logic {
        OP_INC    = 1'b0,
        OP_DECIDE = 1'b1
    } t_op;

    localparam logic [CODE_W-1:0] CODE_X = 3'd4;
    localparam logic [CODE_W-1:0] CODE_F = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_KEEP_FRACTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH     = 1'b1;

    localparam logic [KEEP_W-1:0]      KEEP_FRACTION_RESET = 17'd65536;
    localparam logic [MIN_DEPTH_W-1:0] MIN_DEPTH_RESET     = 16'd2;

    typedef struct packed {
        logic                en;
        logic [BASE_W-1:0]   base;
        logic [AMOUNT_W-1:0] amount;
    } t_inc_cmd;

    typedef struct packed {
        logic                load;
        logic                take;
        logic [AMOUNT_W-1:0] depth;
    } t_dec_ctl;

endpackage

>>> rtl/core/base_extension_vote_unit.sv
// Top level of the base extension vote unit: input register, configuration, counters, vote.
// A decide word passes through the input register and the result register to the master side.
// One word per cycle unless a decide word stalls; threshold multiply and vote in one stage.
// A decide word waits in the input register while the result register is not taken.
// Reset (synchronous, active low): counters zero, keep_fraction 1.0, min_depth 2,
// input and result registers empty.
module base_extension_vote_unit #(
    parameter int COUNT_WIDTH = bev_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bev_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // base[1:0], amount[17:2], zero
    input  logic [0:0]                        s_axis_tuser,   // op[0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bev_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // ext_code[2:0], all_zero[3], zero
    input  logic                              i_cfg_we,
    input  logic [bev_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bev_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bev_pkg::*;

    logic [KEEP_W-1:0]      r_keep_fraction;
    logic [MIN_DEPTH_W-1:0] r_min_depth;

    logic                   r_in_valid;
    logic                   n_in_valid;
    t_op                    r_in_op;
    logic [BASE_W-1:0]      r_in_base;
    logic [AMOUNT_W-1:0]    r_in_amount;

    logic                   w_accept;
    logic                   w_advance;
    logic                   w_out_valid;
    logic [CODE_W-1:0]      w_out_code;
    logic                   w_out_zero;
    t_inc_cmd               w_inc;
    t_dec_ctl               w_dec;

    logic [NUM_BASES-1:0][COUNT_WIDTH-1:0] w_counts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_fraction <= KEEP_FRACTION_RESET;
            r_min_depth     <= MIN_DEPTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEEP_FRACTION: r_keep_fraction <= i_cfg_data[KEEP_W-1:0];
                REG_MIN_DEPTH:     r_min_depth     <= i_cfg_data[MIN_DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_advance = r_in_valid &&
                       (r_in_op == OP_INC || !w_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op     <= t_op'(s_axis_tuser[0]);
            r_in_base   <= s_axis_tdata[BASE_W-1:0];
            r_in_amount <= s_axis_tdata[BASE_W+AMOUNT_W-1:BASE_W];
        end
    end

    always_comb begin
        w_inc.en     = w_advance && (r_in_op == OP_INC);
        w_inc.base   = r_in_base;
        w_inc.amount = r_in_amount;
        w_dec.load   = w_advance && (r_in_op == OP_DECIDE);
        w_dec.take   = m_axis_tready;
        w_dec.depth  = r_in_amount;
    end

    bev_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_inc    (w_inc),
        .o_counts (w_counts)
    );

    bev_decide #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decide (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_dec),
        .i_counts        (w_counts),
        .i_keep_fraction (r_keep_fraction),
        .i_min_depth     (r_min_depth),
        .o_valid         (w_out_valid),
        .o_code          (w_out_code),
        .o_all_zero      (w_out_zero)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - CODE_W - 1)'(0), w_out_zero, w_out_code};

endmodule

>>> rtl/core/bev_counters.sv
// Bank of four saturating base counters.
module bev_counters #(
    parameter int COUNT_WIDTH = bev_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  bev_pkg::t_inc_cmd                                i_inc,
    output logic [bev_pkg::NUM_BASES-1:0][COUNT_WIDTH-1:0]   o_counts
);
    import bev_pkg::*;

    localparam int SumW = ((COUNT_WIDTH > AMOUNT_W) ? COUNT_WIDTH : AMOUNT_W) + 1;
    localparam logic [SumW-1:0] CountMax = SumW'((64'd1 << COUNT_WIDTH) - 64'd1);

    logic [NUM_BASES-1:0][COUNT_WIDTH-1:0] r_counts;
    logic [NUM_BASES-1:0][COUNT_WIDTH-1:0] n_counts;
    logic [SumW-1:0]                       w_sum;

    always_comb begin
        w_sum    = SumW'(r_counts[i_inc.base]) + SumW'(i_inc.amount);
        n_counts = r_counts;
        if (i_inc.en) begin
            // clamp at the counter maximum
            n_counts[i_inc.base] = (w_sum < CountMax) ? COUNT_WIDTH'(w_sum)
                                                      : COUNT_WIDTH'(CountMax);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
        end else begin
            r_counts <= n_counts;
        end
    end

    assign o_counts = r_counts;

endmodule

>>> rtl/core/bev_decide.sv
// Threshold, top and runner-up vote, and the result register.
module bev_decide #(
    parameter int COUNT_WIDTH = bev_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  bev_pkg::t_dec_ctl                                i_ctl,
    input  logic [bev_pkg::NUM_BASES-1:0][COUNT_WIDTH-1:0]   i_counts,
    input  logic [bev_pkg::KEEP_W-1:0]                       i_keep_fraction,
    input  logic [bev_pkg::MIN_DEPTH_W-1:0]                  i_min_depth,
    output logic                                             o_valid,
    output logic [bev_pkg::CODE_W-1:0]                       o_code,
    output logic                                             o_all_zero
);
    import bev_pkg::*;

    localparam int ProdW = KEEP_W + AMOUNT_W;
    localparam int CmpW  = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    logic [ProdW-1:0]       w_prod;
    logic [THR_W-1:0]       w_thr_mul;
    logic [THR_W-1:0]       w_thr;
    logic [BASE_W-1:0]      w_top;
    logic [COUNT_WIDTH-1:0] w_runner;
    logic                   w_have;
    logic [CODE_W-1:0]      w_code;
    logic                   w_zero;

    logic                   r_valid;
    logic                   n_valid;
    logic [CODE_W-1:0]      r_code;
    logic                   r_all_zero;

    always_comb begin
        w_prod    = ProdW'(i_keep_fraction) * ProdW'(i_ctl.depth);
        w_thr_mul = w_prod[ProdW-1:FRAC_BITS];
        w_thr     = (THR_W'(i_min_depth) > w_thr_mul) ? THR_W'(i_min_depth) : w_thr_mul;

        // ties go to the higher base
        w_top = '0;
        for (int i = 1; i < NUM_BASES; i++) begin
            if (i_counts[i] >= i_counts[w_top]) begin
                w_top = BASE_W'(i);
            end
        end

        w_runner = '0;
        w_have   = 1'b0;
        for (int i = 0; i < NUM_BASES; i++) begin
            if (BASE_W'(i) != w_top && (!w_have || i_counts[i] > w_runner)) begin
                w_runner = i_counts[i];
                w_have   = 1'b1;
            end
        end

        if (CmpW'(i_counts[w_top]) < CmpW'(w_thr)) begin
            w_code = CODE_X;
        end else if (CmpW'(w_runner) >= CmpW'(w_thr)) begin
            w_code = CODE_F;
        end else begin
            w_code = CODE_W'(w_top);
        end

        w_zero = (i_counts == '0);
    end

    always_comb begin
        if (i_ctl.load) begin
            n_valid = 1'b1;
        end else if (i_ctl.take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_code     <= w_code;
            r_all_zero <= w_zero;
        end
    end

    assign o_valid    = r_valid;
    assign o_code     = r_code;
    assign o_all_zero = r_all_zero;

endmodule

>>> rtl/core/bev_checker.sv
// Port-level checks of the base extension vote unit, bound to the top level.
module bev_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bev_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import bev_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[CODE_W-1:0] != 3'd6 &&
                          m_axis_tdata[CODE_W-1:0] != 3'd7)
        else $error("extension code out of range");

    a_empty_vote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[CODE_W] |->
            m_axis_tdata[CODE_W-1:0] == CODE_X || m_axis_tdata[CODE_W-1:0] == CODE_F)
        else $error("empty counters voted for a base");

endmodule

bind base_extension_vote_unit bev_checker u_bev_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
